/* rtl/core/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies property b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// property a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* rtl/core/dpc_pkg.sv */
// shared constants for the divisor pair counter
// no dependencies
package dpc_pkg;

  localparam int NumberWidthDefault = 40;
  localparam int CountWidth = 13;
  localparam logic [CountWidth-1:0] CountMax = '1;

endpackage

/* rtl/core/dpc_front.sv */
// front part: accepts transactions and classifies them (zero bound)
// depends on dpc_pkg
module dpc_front
  import dpc_pkg::*;
#(
  parameter int NUMBER_WIDTH = NumberWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUMBER_WIDTH-1:0] number,
  input  logic [NUMBER_WIDTH-1:0] min_divisor,
  output logic                    q_valid,
  input  logic                    q_stall,
  output logic [NUMBER_WIDTH-1:0] q_number,
  output logic [NUMBER_WIDTH-1:0] q_start
);

  // one-entry skid queue toward the back part
  logic                    full;
  logic [NUMBER_WIDTH-1:0] num_reg;
  logic [NUMBER_WIDTH-1:0] start_reg;

  assign in_stall = full && q_stall;
  assign q_valid  = full;
  assign q_number = num_reg;
  assign q_start  = start_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (!q_stall) begin
      full <= 1'b0;
    end
  end

  // a zero bound counts from one
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      num_reg   <= number;
      start_reg <= (min_divisor == '0) ? NUMBER_WIDTH'(1) : min_divisor;
    end
  end

endmodule

/* rtl/core/dpc_back.sv */
// back part: iterative trial division over candidates and counting
// depends on dpc_pkg
module dpc_back
  import dpc_pkg::*;
#(
  parameter int NUMBER_WIDTH = NumberWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_stall,
  input  logic [NUMBER_WIDTH-1:0] q_number,
  input  logic [NUMBER_WIDTH-1:0] q_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CountWidth-1:0]   divisor_count
);

  localparam int SqW = 2 * NUMBER_WIDTH + 2;
  localparam int RemW = NUMBER_WIDTH;
  localparam int StepW = $clog2(NUMBER_WIDTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]              state;
  logic [NUMBER_WIDTH-1:0] n;
  logic [NUMBER_WIDTH-1:0] n_shift;
  logic [NUMBER_WIDTH-1:0] mul_bits;
  logic [NUMBER_WIDTH:0]   d;
  logic [SqW-1:0]          sq;
  logic [CountWidth-1:0]   cnt;
  logic [RemW:0]           rem;
  logic [StepW-1:0]        step;

  // restoring division, one quotient bit per cycle
  logic [RemW+1:0] rem_shift;
  logic [RemW+1:0] rem_sub;
  assign rem_shift = {rem, n_shift[NUMBER_WIDTH-1]};
  assign rem_sub   = rem_shift - (RemW+2)'(d);

  assign q_stall       = (state != S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign divisor_count = cnt;

  // sequencer: square the start once, then compare, divide, advance
  // the square of the next candidate is kept as sq + 2d + 1
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            n        <= q_number;
            d        <= {1'b0, q_start};
            mul_bits <= q_start;
            sq       <= '0;
            step     <= '0;
            cnt      <= '0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          // shift-add square, multiplier bits msb first
          sq       <= {sq[SqW-2:0], 1'b0} + (mul_bits[NUMBER_WIDTH-1] ? SqW'(d) : SqW'(0));
          mul_bits <= {mul_bits[NUMBER_WIDTH-2:0], 1'b0};
          if (step == StepW'(NUMBER_WIDTH - 1)) begin
            state <= S_CMP;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CMP: begin
          if (d[NUMBER_WIDTH] || sq >= SqW'(n)) begin
            state <= S_OUT;
          end else begin
            rem     <= '0;
            step    <= '0;
            n_shift <= n;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (!rem_sub[RemW+1]) begin
            rem <= rem_sub[RemW:0];
          end else begin
            rem <= rem_shift[RemW:0];
          end
          n_shift <= {n_shift[NUMBER_WIDTH-2:0], 1'b0};
          if (step == StepW'(NUMBER_WIDTH - 1)) begin
            if ((rem_sub[RemW+1] ? rem_shift : rem_sub) == '0 && cnt != CountMax) begin
              cnt <= cnt + 1'b1;
            end
            d     <= d + 1'b1;
            sq    <= sq + SqW'({d, 1'b1});
            state <= S_CMP;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/divisor_pair_counter_top.sv */
// Divisor pair counter. Input channel: number, min_divisor with in_valid /
// in_stall; output channel: divisor_count with out_valid / out_stall.
// For each transaction the block returns how many divisors d of number
// satisfy d >= min_divisor and d*d < number (saturating at 8191).
// The front part registers a transaction into a one-entry queue; the back
// part squares the bound once (shift-add) and then walks candidates upward
// while d*d < number; each candidate takes a compare and then a restoring
// division with one bit per cycle. One transaction is processed at a time
// and one more can wait in the queue; the back part returns to idle once its
// result leaves and takes the next one from there.
// Reset empties the queue and idles the back part; nothing is kept
// between transactions.
// When the receiver stalls, the result holds on the ports and the back
// part takes no new work; the front then stalls once its queue is full.
// depends on dpc_pkg, dpc_front, dpc_back, assert_macros.svh
`include "assert_macros.svh"
module divisor_pair_counter_top
  import dpc_pkg::*;
#(
  parameter int NUMBER_WIDTH = NumberWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUMBER_WIDTH-1:0] number,
  input  logic [NUMBER_WIDTH-1:0] min_divisor,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CountWidth-1:0]   divisor_count
);

  logic                    q_valid;
  logic                    q_stall;
  logic [NUMBER_WIDTH-1:0] q_number;
  logic [NUMBER_WIDTH-1:0] q_start;

  dpc_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .number, .min_divisor,
    .q_valid, .q_stall, .q_number, .q_start
  );

  dpc_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_stall, .q_number, .q_start,
    .out_valid, .out_stall, .divisor_count
  );

  // queue entry never has a zero start
  `ASSERT_IMPLIES(a_start_nonzero, clk, rst, q_valid, q_start != '0)
  // a result leaves before the back part takes new work
  `ASSERT_IMPLIES(a_busy_out, clk, rst, out_valid, q_stall)
  // a stalled result holds its value
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, $stable(divisor_count))

endmodule
